@@ sv/tkss_pkg.sv @@
package tkss_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEEP_W       = 5;
  localparam int SCORE_W      = 32;
  localparam int DOC_W        = 32;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;
  localparam int REG_IDX_W    = 1;

  localparam logic [KEEP_W-1:0]    KEEP_RESET     = 5'd10;
  localparam logic [REG_IDX_W-1:0] REG_KEEP_COUNT = 1'b0;

  localparam logic KIND_OFFER = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [SCORE_W-1:0] score;
    logic [DOC_W-1:0]   doc_id;
  } in_word_t;

  typedef struct packed {
    logic [SCORE_W-1:0] out_score;
    logic [DOC_W-1:0]   out_doc;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic load_item;
    logic compare;
    logic update;
    logic replace;
    logic pop;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
    logic beats_last;
  } dp_sts_t;

endpackage

@@ sv/tkss_dpath.sv @@
module tkss_dpath import tkss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic             clk_i,
  input  in_word_t         in_word_i,
  input  dp_cmd_t          cmd_i,
  input  logic [CNT_W-1:0] held_i,
  output dp_sts_t          sts_o,
  output out_word_t        out_word_o
);

  in_word_t           item_q;
  logic [CAPACITY-1:0] cmp_q;
  logic [SCORE_W-1:0] score_q [CAPACITY];
  logic [SCORE_W-1:0] score_d [CAPACITY];
  logic [DOC_W-1:0]   doc_q   [CAPACITY];
  logic [DOC_W-1:0]   doc_d   [CAPACITY];
  out_word_t          out_q;

  logic [CNT_W-1:0]    lim;
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] held_mask;
  logic [CAPACITY-1:0] take_prev;
  logic [CAPACITY-1:0] take_new;

  assign lim = cmd_i.replace ? held_i - CNT_W'(1) : held_i;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      held_mask[i] = CNT_W'(i) < held_i;
      lt[i]        = cmp_q[i] && (CNT_W'(i) < lim);
    end
    take_prev = lt << 1;
    for (int i = 0; i < CAPACITY; i++) begin
      take_new[i] = !take_prev[i] && (lt[i] || (CNT_W'(i) == lim));
    end
  end

  assign sts_o.kind       = item_q.kind;
  assign sts_o.beats_last = |(cmp_q & held_mask);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      score_d[i] = score_q[i];
      doc_d[i]   = doc_q[i];
    end
    if (cmd_i.update) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (take_new[i]) begin
          score_d[i] = item_q.score;
          doc_d[i]   = item_q.doc_id;
        end
      end
      for (int i = 1; i < CAPACITY; i++) begin
        if (take_prev[i]) begin
          score_d[i] = score_q[i-1];
          doc_d[i]   = doc_q[i-1];
        end
      end
    end else if (cmd_i.pop) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        score_d[i] = score_q[i+1];
        doc_d[i]   = doc_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_word_i;
    end
    if (cmd_i.compare) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cmp_q[i] <= score_q[i] < item_q.score;
      end
    end
    if (cmd_i.pop) begin
      out_q.out_score <= score_q[0];
      out_q.out_doc   <= doc_q[0];
      out_q.last      <= cmd_i.last;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      score_q[i] <= score_d[i];
      doc_q[i]   <= doc_d[i];
    end
  end

  assign out_word_o = out_q;

endmodule

@@ sv/tkss_ctrl.sv @@
module tkss_ctrl import tkss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_stall_i,
  input  logic [CNT_W-1:0] keep_i,
  input  dp_sts_t          sts_i,
  output dp_cmd_t          cmd_o,
  output logic [CNT_W-1:0] held_o,
  output logic             in_stall_o,
  output logic             out_valid_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_FLUSH
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] held_q, held_d;
  logic             out_valid_q, out_valid_d;
  logic             do_insert, do_replace, can_pop;

  assign do_insert  = (keep_i != '0) && (held_q < keep_i);
  assign do_replace = (keep_i != '0) && !(held_q < keep_i) && (held_q != '0) &&
                      sts_i.beats_last;
  assign can_pop    = (held_q != '0) && (!out_valid_q || !out_stall_i);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    held_d  = held_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = (sts_i.kind == KIND_FLUSH) ? ST_FLUSH : ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update  = do_insert || do_replace;
        cmd_o.replace = do_replace;
        if (do_insert) begin
          held_d = held_q + CNT_W'(1);
        end
        state_d = ST_IDLE;
      end
      ST_FLUSH: begin
        if (held_q == '0) begin
          state_d = ST_IDLE;
        end else if (can_pop) begin
          cmd_o.pop  = 1'b1;
          cmd_o.last = held_q == CNT_W'(1);
          held_d     = held_q - CNT_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.pop || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign held_o      = held_q;
  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |-> held_q != '0)
    else $error("pop from empty store");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.update && !cmd_o.replace) |=> held_q == $past(held_q) + CNT_W'(1))
    else $error("insert did not grow store");

  a_replace_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.replace |-> (held_q >= keep_i) && (held_q != '0))
    else $error("replace while store not full");
`endif

endmodule

@@ sv/top_k_score_select.sv @@
// Keeps the keep_count highest scoring documents offered since the last flush, sorted
// descending, equal scores in arrival order. An offer word is accepted, compared in parallel
// against every kept entry and shift-inserted into the sorted register row. After a flush
// word, entries leave the head of the row through the output register at one a cycle while
// the output is not stalled; the last entry carries last. A flush with nothing held emits
// nothing. keep_count at byte address 0 (reset 10) saturates at CAPACITY. The user must
// write it only while idle; the block itself does not enforce this.
module top_k_score_select import tkss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [KEEP_W-1:0]    keep_q;
  logic [CNT_W-1:0]     keep_eff;
  logic [CNT_W-1:0]     held;
  logic [REG_IDX_W-1:0] reg_idx;
  dp_cmd_t              cmd;
  dp_sts_t              sts;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= KEEP_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_KEEP_COUNT)) begin
      keep_q <= pwdata[KEEP_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_KEEP_COUNT) ? DATA_W'(keep_q) : '0;

  always_comb begin
    if (int'(keep_q) > CAPACITY) begin
      keep_eff = CNT_W'(CAPACITY);
    end else begin
      keep_eff = CNT_W'(keep_q);
    end
  end

  tkss_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .keep_i      (keep_eff),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .held_o      (held),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  tkss_dpath #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_dpath (
    .clk_i      (clk_i),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .held_i     (held),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule

@@ tb/top_k_score_select_test.sv @@
`timescale 1ns / 100ps

module top_k_score_select_test;
  import tkss_pkg::*;

  class top_k_board;
    logic [SCORE_W-1:0] kept_score [CAPACITY_DEF];
    logic [DOC_W-1:0]   kept_doc   [CAPACITY_DEF];
    int unsigned        held;
    logic [KEEP_W-1:0]  keep;
    out_word_t          ranked_q [$];
    int unsigned        errors;

    function new();
      held   = 0;
      keep   = KEEP_RESET;
      errors = 0;
    endfunction

    function int unsigned pending();
      return ranked_q.size();
    endfunction

    function void enqueue(out_word_t w);
      ranked_q.insert(ranked_q.size(), w);
    endfunction

    // insert after every entry scoring at least s, so equal scores keep arrival order
    function void place(int unsigned n, logic [SCORE_W-1:0] s, logic [DOC_W-1:0] d);
      int unsigned pos;
      pos = 0;
      while (pos < n && kept_score[pos] >= s) pos++;
      for (int unsigned i = n; i > pos; i--) begin
        kept_score[i] = kept_score[i-1];
        kept_doc[i]   = kept_doc[i-1];
      end
      kept_score[pos] = s;
      kept_doc[pos]   = d;
    endfunction

    function void note_word(in_word_t w);
      int unsigned k;
      out_word_t   ranked;
      k = (keep > CAPACITY_DEF) ? CAPACITY_DEF : keep;
      if (w.kind == KIND_OFFER) begin
        if (k == 0) return;
        if (held < k) begin
          place(held, w.score, w.doc_id);
          held++;
        end else if (held > 0 && w.score > kept_score[held-1]) begin
          place(held - 1, w.score, w.doc_id);
        end
      end else begin
        for (int unsigned i = 0; i < held; i++) begin
          ranked.out_score = kept_score[i];
          ranked.out_doc   = kept_doc[i];
          ranked.last      = (i + 1 == held);
          enqueue(ranked);
        end
        held = 0;
      end
    endfunction

    task report(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(input out_word_t got);
      out_word_t want;
      if (ranked_q.size() == 0) begin
        report($sformatf("unexpected word score %h doc %h last %b",
                         got.out_score, got.out_doc, got.last));
        return;
      end
      want = ranked_q.pop_front();
      if (got.out_score !== want.out_score)
        report($sformatf("score %h, want %h", got.out_score, want.out_score));
      if (got.out_doc !== want.out_doc)
        report($sformatf("doc %h, want %h", got.out_doc, want.out_doc));
      if (got.last !== want.last)
        report($sformatf("last %b, want %b (doc %h)", got.last, want.last, want.out_doc));
    endtask
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_word_t          in_word_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_word_t         out_word_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [DATA_W-1:0] pwdata      = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  top_k_board  board = new();
  int unsigned stall_left = 0;
  int unsigned items_sent = 0;
  bit          idle_in = 1'b1;
  bit          idle_out = 1'b1;

  top_k_score_select i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(out_word_o);
      stall_left = idle_out ? $urandom_range(0, 7) : 0;
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = idle_in ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_word(w);
    if (!(w.kind == KIND_OFFER && board.keep == 0)) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic offer(input logic [SCORE_W-1:0] s, input logic [DOC_W-1:0] d);
    send_word('{kind: KIND_OFFER, score: s, doc_id: d});
  endtask

  task automatic flush_store();
    send_word('{kind: KIND_FLUSH, score: $urandom, doc_id: $urandom});
  endtask

  // drop valid and let the block drain before touching the register
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({REG_KEEP_COUNT, 2'b00});
    pwdata  <= DATA_W'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.keep = v;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== DATA_W'(v))
      board.report($sformatf("keep_count read %h, want %h", prdata, v));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [KEEP_W-1:0] pick_keep();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return KEEP_W'($urandom_range(CAPACITY_DEF + 1, (1 << KEEP_W) - 1));
      2:       return KEEP_W'(CAPACITY_DEF);
      3:       return KEEP_W'(1);
      default: return KEEP_W'($urandom_range(2, CAPACITY_DEF - 1));
    endcase
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2:       return SCORE_W'($urandom_range(0, 7));
      3:       return {SCORE_W'($urandom_range(0, 3)) << 16};
      4:       return $urandom_range(0, 1) ? '1 : '0;
      default: return 32'h8000_0000 | SCORE_W'($urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    int unsigned eff;
    int unsigned n;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset keep count: empty flush, ties, eviction of the latest equal minimum
    flush_store();
    offer(32'd5, 32'd1);
    offer(32'd5, 32'd2);
    offer(32'd5, 32'd3);
    offer('1, '1);
    offer('0, '0);
    offer(32'd7, 32'd4);
    offer(32'd8, 32'd5);
    offer(32'd9, 32'd6);
    offer(32'd10, 32'd7);
    offer(32'd11, 32'd8);
    offer(32'd12, 32'd9);
    offer(32'd5, 32'd10);
    offer(32'd6, 32'd11);
    flush_store();

    settle();
    write_keep('0);
    offer(32'd1, 32'd1);
    flush_store();

    settle();
    write_keep('1);
    offer(32'd100, 32'd1);
    offer(32'd200, 32'd2);
    offer(32'd300, 32'd3);
    offer(32'd400, 32'd4);
    settle();
    write_keep(KEEP_W'(2));
    offer(32'd250, 32'd5);
    flush_store();

    settle();
    write_keep(KEEP_W'(1));
    offer(32'd3, 32'd1);
    offer(32'd3, 32'd2);
    flush_store();

    while (items_sent < 460) begin
      settle();
      idle_in  = ($urandom_range(0, 3) != 0);
      idle_out = ($urandom_range(0, 3) != 0);
      write_keep(pick_keep());
      eff = (board.keep > CAPACITY_DEF) ? CAPACITY_DEF : board.keep;
      repeat ($urandom_range(1, 4)) begin
        n = $urandom_range(0, 2 * eff + 3);
        repeat (n) offer(pick_score(), $urandom);
        // leave entries held now and then, so the next keep count meets a filled store
        if ($urandom_range(0, 4) != 0) flush_store();
      end
    end

    flush_store();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (board.pending() != 0)
      board.report($sformatf("%0d words never arrived", board.pending()));
    if (board.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #10000000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
sv/tkss_pkg.sv
sv/tkss_dpath.sv
sv/tkss_ctrl.sv
sv/top_k_score_select.sv
tb/top_k_score_select_test.sv
